>>> hw/rtl/srect_pkg.sv
// Shared types and codes for the skyline rectangle allocator.
package srect_pkg;

  // Width of a rectangle size in cells: (13-bit extent >> 4) + 1 reaches 512
  localparam int SizeW = 10;

  // Item kinds carried in tuser
  localparam logic [1:0] KIND_ALLOC   = 2'd0;
  localparam logic [1:0] KIND_RESTART = 2'd1;
  localparam logic [1:0] KIND_FINISH  = 2'd2;

  // Result status codes
  localparam logic [2:0] STAT_PLACED  = 3'd0;
  localparam logic [2:0] STAT_SKIPPED = 3'd1;
  localparam logic [2:0] STAT_TOO_BIG = 3'd2;
  localparam logic [2:0] STAT_LIMIT   = 3'd3;
  localparam logic [2:0] STAT_DONE    = 3'd4;

  // Top-level sequencer
  typedef enum logic [2:0] {
    T_CLEAR,
    T_IDLE,
    T_SCAN,
    T_WAIT,
    T_FILL,
    T_RESULT
  } top_state_t;

  // Scan engine sequencer
  typedef enum logic [2:0] {
    SC_IDLE,
    SC_FWD,
    SC_FWD_END,
    SC_BWD,
    SC_BWD_END,
    SC_DONE
  } scan_state_t;

  // Scan engine status toward the sequencer
  typedef struct packed {
    logic done;
    logic found;
  } scan_sts_t;

endpackage

>>> hw/rtl/skyline_rect_allocator.sv
// Top level of the skyline rectangle allocator.
// Packs rectangles into PAGE_WIDTH x PAGE_HEIGHT cell pages bottom-left first, keeping one
// height per column in a RAM. One item is handled at a time. After reset, and for a restart
// item, a clearing pass writes the skyline RAM one column a cycle, during which no item is
// taken. An allocate runs a forward pass (block-prefix maxima into a second RAM) and a
// backward pass (window maxima) over the columns, then writes w columns of the new height.
// When the page has to be closed a clearing pass and a second scan follow. Skipped and
// locked allocations, finish items and the unused kind go straight to the result. The
// single RAM read port per pass sets the scan length. The result sits in an output
// register, so a new item is taken while it waits.
module skyline_rect_allocator #(
  parameter int PAGE_WIDTH = 512,
  parameter int PAGE_HEIGHT = 512,
  parameter int MAX_PAGES = 128
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,   // extent_s[12:0], extent_t[25:13], zero[31:26]
  input  logic [2:0]  s_tuser,   // kind[1:0], skip_surface[2]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,   // page[7:0], pos_x[16:8], pos_y[25:17], zero[31:26]
  output logic [2:0]  m_tuser    // status[2:0]
);
  import srect_pkg::*;

  localparam int CW = $clog2(PAGE_WIDTH);
  localparam int HW = $clog2(PAGE_HEIGHT + 1);
  localparam int SUMW = ((HW > SizeW) ? HW : SizeW) + 1;
  localparam logic [CW-1:0] LastCol = CW'(PAGE_WIDTH - 1);
  localparam logic [7:0] PageLimit = 8'(MAX_PAGES);

  function automatic logic [SizeW-1:0] cells(input logic [12:0] ext);
    return SizeW'(ext[12:4]) + SizeW'(1);
  endfunction

  top_state_t       state, state_next, clr_ret, clr_ret_next;
  logic [CW-1:0]    col, col_next;
  logic [SizeW-1:0] fill_left, fill_left_next;
  logic [SizeW-1:0] size_w, size_w_next, size_h, size_h_next;
  logic             retry, retry_next;
  logic [7:0]       page, page_next, page_inc;
  logic [2:0]       res_status, res_status_next;
  logic [CW-1:0]    res_x, res_x_next;
  logic [HW-1:0]    res_y, res_y_next;
  logic             scan_start, ram_we, out_load, locked, fit_ok;
  logic [1:0]       in_kind;
  logic             in_skip;
  logic [HW-1:0]    ram_wdata, fill_val;
  logic [CW-1:0]    h_raddr;
  logic [HW-1:0]    h_rdata;
  scan_sts_t        sts;
  logic [CW-1:0]    best_x;
  logic [HW-1:0]    best_y;

  assign in_kind = s_tuser[1:0];
  assign in_skip = s_tuser[2];
  assign s_tready = (state == T_IDLE);
  assign locked = (page >= PageLimit);
  assign page_inc = page + 8'd1;
  assign fit_ok = (SUMW'(best_y) + SUMW'(size_h)) <= SUMW'(PAGE_HEIGHT);
  assign fill_val = HW'(SUMW'(res_y) + SUMW'(size_h));
  assign ram_wdata = (state == T_FILL) ? fill_val : '0;

  // Column heights
  srect_ram #(.WIDTH(HW), .DEPTH(PAGE_WIDTH)) u_height_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (col),
    .wdata (ram_wdata),
    .raddr (h_raddr),
    .rdata (h_rdata)
  );

  srect_scan #(.PAGE_WIDTH(PAGE_WIDTH), .PAGE_HEIGHT(PAGE_HEIGHT)) u_scan (
    .clk     (clk),
    .rst     (rst),
    .start   (scan_start),
    .size_w  (size_w),
    .h_raddr (h_raddr),
    .h_rdata (h_rdata),
    .sts     (sts),
    .best_x  (best_x),
    .best_y  (best_y)
  );

  // Next state and item handling
  always_comb begin
    state_next = state;
    clr_ret_next = clr_ret;
    col_next = col;
    fill_left_next = fill_left;
    size_w_next = size_w;
    size_h_next = size_h;
    retry_next = retry;
    page_next = page;
    res_status_next = res_status;
    res_x_next = res_x;
    res_y_next = res_y;
    scan_start = 1'b0;
    ram_we = 1'b0;
    out_load = 1'b0;
    unique case (state)
      T_CLEAR: begin
        ram_we = 1'b1;
        if (col == LastCol) begin
          col_next = '0;
          state_next = clr_ret;
        end else begin
          col_next = col + CW'(1);
        end
      end
      T_IDLE: begin
        if (s_tvalid) begin
          size_w_next = cells(s_tdata[12:0]);
          size_h_next = cells(s_tdata[25:13]);
          retry_next = 1'b0;
          res_x_next = '0;
          res_y_next = '0;
          res_status_next = STAT_DONE;
          state_next = T_RESULT;
          unique case (in_kind)
            KIND_ALLOC: begin
              if (locked) begin
                res_status_next = STAT_LIMIT;
              end else if (in_skip) begin
                res_status_next = STAT_SKIPPED;
              end else begin
                state_next = T_SCAN;
              end
            end
            KIND_RESTART: begin
              page_next = '0;
              col_next = '0;
              clr_ret_next = T_RESULT;
              state_next = T_CLEAR;
            end
            KIND_FINISH: begin
              if (locked) begin
                res_status_next = STAT_LIMIT;
              end else begin
                page_next = page_inc;
                if (page_inc == PageLimit) begin
                  res_status_next = STAT_LIMIT;
                end
              end
            end
            default: res_status_next = STAT_DONE;
          endcase
        end
      end
      T_SCAN: begin
        scan_start = 1'b1;
        state_next = T_WAIT;
      end
      T_WAIT: begin
        if (sts.done) begin
          if (sts.found && fit_ok) begin
            res_status_next = STAT_PLACED;
            res_x_next = best_x;
            res_y_next = best_y;
            col_next = best_x;
            fill_left_next = size_w;
            state_next = T_FILL;
          end else if (!retry) begin
            // close the page; retry on a cleared skyline unless the limit is hit
            page_next = page_inc;
            if (page_inc == PageLimit) begin
              res_status_next = STAT_LIMIT;
              state_next = T_RESULT;
            end else begin
              retry_next = 1'b1;
              col_next = '0;
              clr_ret_next = T_SCAN;
              state_next = T_CLEAR;
            end
          end else begin
            res_status_next = STAT_TOO_BIG;
            state_next = T_RESULT;
          end
        end
      end
      T_FILL: begin
        ram_we = 1'b1;
        col_next = col + CW'(1);
        fill_left_next = fill_left - SizeW'(1);
        if (fill_left == SizeW'(1)) begin
          state_next = T_RESULT;
        end
      end
      T_RESULT: begin
        if (!m_tvalid || m_tready) begin
          out_load = 1'b1;
          state_next = T_IDLE;
        end
      end
      default: state_next = T_IDLE;
    endcase
  end

  // Hold control state; reset starts with a clearing pass
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= T_CLEAR;
      clr_ret <= T_IDLE;
      col <= '0;
      page <= '0;
      retry <= 1'b0;
    end else begin
      state <= state_next;
      clr_ret <= clr_ret_next;
      col <= col_next;
      page <= page_next;
      retry <= retry_next;
    end
  end

  // Item payload registers
  always_ff @(posedge clk) begin
    fill_left <= fill_left_next;
    size_w <= size_w_next;
    size_h <= size_h_next;
    res_status <= res_status_next;
    res_x <= res_x_next;
    res_y <= res_y_next;
  end

  // Output word register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      m_tuser <= res_status;
      m_tdata <= {6'd0, 9'(res_y), 9'(res_x), page};
    end
  end

endmodule

>>> hw/rtl/srect_ram.sv
// Generic single-clock RAM: one write port, one read port, registered read data.
module srect_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write, then register the read word
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> hw/rtl/srect_scan.sv
// Skyline scan engine: finds the leftmost window whose highest column is lowest.
module srect_scan #(
  parameter int PAGE_WIDTH = 512,
  parameter int PAGE_HEIGHT = 512,
  localparam int CW = $clog2(PAGE_WIDTH),
  localparam int HW = $clog2(PAGE_HEIGHT + 1)
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     start,
  input  logic [srect_pkg::SizeW-1:0] size_w,
  output logic [CW-1:0]            h_raddr,
  input  logic [HW-1:0]            h_rdata,
  output srect_pkg::scan_sts_t     sts,
  output logic [CW-1:0]            best_x,
  output logic [HW-1:0]            best_y
);
  import srect_pkg::*;

  // Window ends stop one column short of the page edge
  localparam logic [CW-1:0] LastCol = CW'(PAGE_WIDTH - 2);
  localparam logic [HW-1:0] Top = HW'(PAGE_HEIGHT);

  scan_state_t     state, state_next;
  logic [CW-1:0]   col, col_next;
  logic [CW-1:0]   lim;
  logic            issue, issue_bwd;
  logic            pipe_vld, pipe_bwd, pipe_cand;
  logic [CW-1:0]   pipe_col;
  logic [SizeW-1:0] off, off_inc, off_dec, wm1;
  logic [HW-1:0]   run, run_new, val;
  logic            restart, take, fits, found;
  logic [12:0]     p_addr_sum;
  logic            p_we;
  logic [CW-1:0]   p_raddr;
  logic [HW-1:0]   p_rdata;

  // Block-prefix maxima from the forward pass
  srect_ram #(.WIDTH(HW), .DEPTH(PAGE_WIDTH)) u_prefix_ram (
    .clk   (clk),
    .we    (p_we),
    .waddr (pipe_col),
    .wdata (run_new),
    .raddr (p_raddr),
    .rdata (p_rdata)
  );

  assign fits = 13'(size_w) < 13'(PAGE_WIDTH);
  assign wm1 = size_w - SizeW'(1);
  assign off_inc = (off == wm1) ? '0 : off + SizeW'(1);
  assign off_dec = (off == '0) ? wm1 : off - SizeW'(1);

  // Read addresses: heights at the column, prefix max at the window end
  assign h_raddr = col;
  assign p_addr_sum = 13'(col) + 13'(size_w) - 13'd1;
  assign p_raddr = p_addr_sum[CW-1:0];

  // Running max restarts at a block start (forward) or block end (backward)
  assign restart = pipe_bwd ? (off == wm1) : (off == '0);
  assign run_new = restart ? h_rdata : ((h_rdata > run) ? h_rdata : run);
  assign val = (run_new > p_rdata) ? run_new : p_rdata;
  assign take = pipe_vld & pipe_bwd & pipe_cand & (val < Top) & (val <= best_y);
  assign p_we = pipe_vld & ~pipe_bwd;

  assign sts.done = (state == SC_DONE);
  assign sts.found = found;

  // Sequence the forward and backward passes
  always_comb begin
    state_next = state;
    col_next = col;
    issue = 1'b0;
    issue_bwd = 1'b0;
    unique case (state)
      SC_IDLE: begin
        col_next = '0;
        if (start) begin
          state_next = fits ? SC_FWD : SC_DONE;
        end
      end
      SC_FWD: begin
        issue = 1'b1;
        if (col == LastCol) begin
          state_next = SC_FWD_END;
        end else begin
          col_next = col + CW'(1);
        end
      end
      SC_FWD_END: begin
        state_next = SC_BWD;
        col_next = LastCol;
      end
      SC_BWD: begin
        issue = 1'b1;
        issue_bwd = 1'b1;
        if (col == '0) begin
          state_next = SC_BWD_END;
        end else begin
          col_next = col - CW'(1);
        end
      end
      SC_BWD_END: state_next = SC_DONE;
      SC_DONE:    state_next = SC_IDLE;
      default:    state_next = SC_IDLE;
    endcase
  end

  // Hold the sequencer and read pipeline
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= SC_IDLE;
      pipe_vld <= 1'b0;
    end else begin
      state <= state_next;
      pipe_vld <= issue;
    end
  end

  // Advance columns, running maxima and the best spot
  always_ff @(posedge clk) begin
    col <= col_next;
    pipe_bwd <= issue_bwd;
    pipe_col <= col;
    pipe_cand <= (col <= lim);
    if (state == SC_IDLE && start) begin
      lim <= CW'(13'(PAGE_WIDTH - 1) - 13'(size_w));
      off <= '0;
      run <= '0;
      best_y <= Top;
      found <= 1'b0;
    end else if (state == SC_BWD && col == LastCol) begin
      // step back from the offset of the last column to the one before
      off <= off_dec;
      run <= '0;
    end else if (pipe_vld) begin
      run <= run_new;
      off <= pipe_bwd ? off_dec : off_inc;
      if (take) begin
        best_y <= val;
        best_x <= pipe_col;
        found <= 1'b1;
      end
    end
  end

endmodule

>>> tb/sv/testbench.sv
`timescale 1ns / 100ps
// Self-checking testbench for skyline_rect_allocator: a driver, a monitor and a predictor.
module testbench;
  import srect_pkg::*;

  localparam int PageW = 512;
  localparam int PageH = 512;
  localparam int PageMax = 128;
  localparam int unsigned PlanItems = 540;
  localparam int unsigned StallLimit = 25000;
  localparam int unsigned MaxPrints = 40;
  localparam logic [1:0] KIND_SPARE = 2'd3;

  typedef struct packed {
    logic [1:0]  kind;
    logic        skip;
    logic [12:0] ext_s;
    logic [12:0] ext_t;
    logic        drain;
  } surf_t;

  typedef struct packed {
    logic [2:0] status;
    logic [7:0] page;
    logic [8:0] pos_x;
    logic [8:0] pos_y;
  } place_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [31:0] s_tdata = '0;   // extent_s[12:0], extent_t[25:13], zero[31:26]
  logic [2:0]  s_tuser = '0;   // kind[1:0], skip_surface[2]
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [31:0] m_tdata;        // page[7:0], pos_x[16:8], pos_y[25:17], zero[31:26]
  logic [2:0]  m_tuser;        // status[2:0]

  surf_t       surf_q[$];
  place_t      placements_due[$];
  int unsigned planned = 0;
  int unsigned sent = 0;
  logic        word_taken = 1'b0;
  int unsigned errors = 0;
  int unsigned quiet = 0;

  // Predicted block state
  int unsigned col_top[PageW];
  logic [7:0]  page_no = '0;

  wire calm = (sent >= 40) && (sent < 100);

  skyline_rect_allocator dut (
    .clk(clk),
    .rst(rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata(s_tdata),
    .s_tuser(s_tuser),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata(m_tdata),
    .m_tuser(m_tuser)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  task automatic report(input string msg);
    if (errors < MaxPrints) $display("%0t mismatch: %s", $realtime, msg);
    errors++;
  endtask

  function automatic void wipe_skyline();
    foreach (col_top[i]) col_top[i] = 0;
  endfunction

  // Bottom-left search: leftmost start whose highest column is strictly lowest
  function automatic bit fit_rect(input int unsigned w, input int unsigned h,
                                  output int unsigned px, output int unsigned py);
    int unsigned best;
    int unsigned bx;
    int unsigned top;
    int unsigned k;
    bit blocked;
    best = PageH;
    bx = 0;
    px = 0;
    py = 0;
    for (int unsigned c = 0; c + w < PageW; c++) begin
      top = 0;
      blocked = 1'b0;
      for (k = 0; k < w && !blocked; k++) begin
        if (col_top[c + k] >= best) blocked = 1'b1;
        else if (col_top[c + k] > top) top = col_top[c + k];
      end
      if (!blocked) begin
        bx = c;
        best = top;
      end
    end
    if (best + h > PageH) return 1'b0;
    for (k = 0; k < w; k++) col_top[bx + k] = best + h;
    px = bx;
    py = best;
    return 1'b1;
  endfunction

  // Advance the page counter; true when it lands on the page cap
  function automatic bit close_page_hits_cap();
    page_no = page_no + 8'd1;
    return page_no == PageMax;
  endfunction

  function automatic place_t pack_step(input surf_t s);
    place_t r;
    int unsigned w;
    int unsigned h;
    int unsigned px;
    int unsigned py;
    bit locked;
    locked = page_no >= PageMax;
    r.status = STAT_DONE;
    px = 0;
    py = 0;
    case (s.kind)
      KIND_ALLOC: begin
        if (locked) begin
          r.status = STAT_LIMIT;
        end else if (s.skip) begin
          r.status = STAT_SKIPPED;
        end else begin
          w = (s.ext_s >> 4) + 1;
          h = (s.ext_t >> 4) + 1;
          if (fit_rect(w, h, px, py)) begin
            r.status = STAT_PLACED;
          end else if (close_page_hits_cap()) begin
            r.status = STAT_LIMIT;
          end else begin
            wipe_skyline();
            r.status = fit_rect(w, h, px, py) ? STAT_PLACED : STAT_TOO_BIG;
          end
        end
      end
      KIND_RESTART: begin
        wipe_skyline();
        page_no = '0;
      end
      KIND_FINISH: begin
        if (locked || close_page_hits_cap()) r.status = STAT_LIMIT;
      end
      default: ;
    endcase
    if (r.status != STAT_PLACED) begin
      px = 0;
      py = 0;
    end
    r.page = page_no;
    r.pos_x = px[8:0];
    r.pos_y = py[8:0];
    return r;
  endfunction

  task automatic push_surf(input logic [1:0] kind, input logic skip,
                           input logic [12:0] es, input logic [12:0] et, input logic drain);
    surf_t s;
    s.kind = kind;
    s.skip = skip;
    s.ext_s = es;
    s.ext_t = et;
    s.drain = drain;
    surf_q.push_back(s);
    planned++;
  endtask

  // Mostly small rectangles, a few up to the full extent range
  function automatic logic [12:0] rand_extent();
    int unsigned pick;
    pick = $urandom_range(99);
    if (pick < 70) return 13'($urandom_range(1023));
    if (pick < 90) return 13'($urandom_range(4095));
    return 13'($urandom_range(8191));
  endfunction

  // Drive the slave side: hold a word until taken, drain before marked words
  always @(negedge clk) begin : drive_surface
    surf_t nxt;
    if (rst) begin
      s_tvalid <= 1'b0;
    end else if (!s_tvalid || word_taken) begin
      if (surf_q.size() != 0 && !(surf_q[0].drain && placements_due.size() != 0) &&
          (calm || $urandom_range(99) >= 38)) begin
        nxt = surf_q.pop_front();
        s_tdata <= {6'b0, nxt.ext_t, nxt.ext_s};
        s_tuser <= {nxt.skip, nxt.kind};
        s_tvalid <= 1'b1;
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  // Stall the master side at random
  always @(negedge clk) begin
    m_tready <= !rst && (calm || $urandom_range(99) >= 38);
  end

  // Predict the result of each accepted word
  always @(posedge clk) begin : take_word
    surf_t got;
    word_taken <= !rst && s_tvalid && s_tready;
    if (rst) begin
      wipe_skyline();
      page_no = '0;
    end else if (s_tvalid && s_tready) begin
      got.kind = s_tuser[1:0];
      got.skip = s_tuser[2];
      got.ext_s = s_tdata[12:0];
      got.ext_t = s_tdata[25:13];
      got.drain = 1'b0;
      placements_due.push_back(pack_step(got));
      sent <= sent + 1;
    end
  end

  // Compare each result word with the oldest prediction
  always @(posedge clk) begin : check_result
    place_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (placements_due.size() == 0) begin
        report($sformatf("result with nothing pending: tuser %0d tdata %h", m_tuser, m_tdata));
      end else begin
        want = placements_due.pop_front();
        if (m_tuser !== want.status)
          report($sformatf("status %0d, want %0d", m_tuser, want.status));
        if (m_tdata[7:0] !== want.page)
          report($sformatf("page %0d, want %0d", m_tdata[7:0], want.page));
        if (m_tdata[16:8] !== want.pos_x)
          report($sformatf("pos_x %0d, want %0d", m_tdata[16:8], want.pos_x));
        if (m_tdata[25:17] !== want.pos_y)
          report($sformatf("pos_y %0d, want %0d", m_tdata[25:17], want.pos_y));
      end
    end
  end

  // End the run when nothing moves on either side for too long
  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      quiet <= 0;
    end else if (quiet >= StallLimit) begin
      $display("FAIL");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  initial begin
    int unsigned pick;
    int unsigned n;
    int unsigned lock_runs;
    logic hold;
    lock_runs = 0;

    // Directed: skip, corners of the extents, forced page closes, control kinds
    push_surf(KIND_ALLOC, 1'b1, 13'h1fff, 13'h1fff, 1'b0);
    push_surf(KIND_ALLOC, 1'b0, 13'd0, 13'd0, 1'b0);
    push_surf(KIND_ALLOC, 1'b0, 13'd15, 13'h1fff, 1'b0);
    push_surf(KIND_ALLOC, 1'b0, 13'h1fff, 13'h1fff, 1'b0);   // wider than any scan: too big
    push_surf(KIND_ALLOC, 1'b0, 13'd8175, 13'd8176, 1'b0);   // fills the fresh page
    push_surf(KIND_ALLOC, 1'b0, 13'd16, 13'd31, 1'b0);       // forces a page close
    push_surf(KIND_FINISH, 1'b0, 13'd0, 13'd0, 1'b1);
    push_surf(KIND_SPARE, 1'b1, 13'h1fff, 13'h0, 1'b0);
    push_surf(KIND_ALLOC, 1'b0, 13'd4096, 13'd4095, 1'b0);
    push_surf(KIND_ALLOC, 1'b0, 13'd4096, 13'd4095, 1'b0);   // stacks on the first
    push_surf(KIND_ALLOC, 1'b0, 13'd0, 13'd0, 1'b0);
    push_surf(KIND_ALLOC, 1'b0, 13'd4096, 13'd0, 1'b0);
    push_surf(KIND_FINISH, 1'b1, 13'h1fff, 13'h1fff, 1'b0);
    push_surf(KIND_RESTART, 1'b0, 13'd0, 13'd0, 1'b0);
    push_surf(KIND_ALLOC, 1'b0, 13'd1, 13'h1fff, 1'b0);
    push_surf(KIND_ALLOC, 1'b0, 13'h1fff, 13'h1fff, 1'b0);
    push_surf(KIND_SPARE, 1'b0, 13'h1555, 13'h0aaa, 1'b0);
    push_surf(KIND_RESTART, 1'b1, 13'h1fff, 13'h1fff, 1'b0);
    push_surf(KIND_FINISH, 1'b1, 13'd0, 13'd0, 1'b0);
    push_surf(KIND_ALLOC, 1'b0, 13'h1555, 13'h0aaa, 1'b0);
    push_surf(KIND_ALLOC, 1'b0, 13'h0aaa, 13'h1555, 1'b0);

    // Random: packing runs, noise, restarts and two runs up to the page cap
    while (planned < PlanItems) begin
      if (lock_runs < 2 && planned >= 150 + 230 * lock_runs) begin
        push_surf(KIND_RESTART, 1'($urandom_range(1)), rand_extent(), rand_extent(), 1'b1);
        repeat (PageMax - 1)
          push_surf(KIND_FINISH, 1'($urandom_range(1)), rand_extent(), rand_extent(), 1'b0);
        // The last close comes from an allocation that cannot fit, or from a finish
        if (lock_runs == 0)
          push_surf(KIND_ALLOC, 1'b0, 13'h1fff, rand_extent(), 1'b0);
        else
          push_surf(KIND_FINISH, 1'b0, rand_extent(), rand_extent(), 1'b0);
        repeat (6)
          push_surf(2'($urandom_range(3)), 1'($urandom_range(1)), rand_extent(),
                    rand_extent(), 1'b0);
        push_surf(KIND_RESTART, 1'b0, rand_extent(), rand_extent(), 1'b0);
        lock_runs++;
      end else begin
        pick = $urandom_range(99);
        hold = ($urandom_range(9) == 0);
        if (pick < 70) begin
          n = $urandom_range(14, 4);
          for (int unsigned i = 0; i < n; i++) begin
            if ($urandom_range(99) < 8)
              push_surf(KIND_FINISH, 1'($urandom_range(1)), rand_extent(), rand_extent(),
                        hold && i == 0);
            else
              push_surf(KIND_ALLOC, ($urandom_range(9) == 0), rand_extent(), rand_extent(),
                        hold && i == 0);
          end
        end else if (pick < 85) begin
          n = $urandom_range(4, 1);
          repeat (n)
            push_surf(2'($urandom_range(3)), 1'($urandom_range(1)),
                      13'($urandom_range(8191)), 13'($urandom_range(8191)), hold);
        end else begin
          push_surf(KIND_RESTART, 1'($urandom_range(1)), rand_extent(), rand_extent(), hold);
        end
      end
    end

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    wait (sent == planned);
    wait (placements_due.size() == 0);
    repeat (20) @(posedge clk);
    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
